// ===== rtl/core/x86pd_pkg.sv =====
// ----------------------------------------------------------------------------
// x86pd_pkg: shared types and constants of the x86 subset predecoder
// Opcode values, result kinds, the result bundle carried from the front
// to the back, and the small classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package x86pd_pkg;

  // Opcode bytes of the recognized subset.
  localparam logic [7:0] OP_PUSH   = 8'h55;
  localparam logic [7:0] OP_RET    = 8'hC3;
  localparam logic [7:0] OP_NOP    = 8'h90;
  localparam logic [7:0] OP_REX    = 8'h48;
  localparam logic [7:0] OP_MOVRM  = 8'h89;
  localparam logic [7:0] OP_MODRM  = 8'hE5;
  localparam logic [7:0] OP_MOVIMM = 8'hB8;
  localparam logic [7:0] OP_ADDIMM = 8'h05;
  localparam logic [7:0] OP_JMP    = 8'hE9;

  // One input byte causes at most this many results.
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);

  // Depth of the bundle queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    KIND_PUSH    = 4'd0,
    KIND_RET     = 4'd1,
    KIND_NOP     = 4'd2,
    KIND_MOVRBP  = 4'd3,
    KIND_MOVEAX  = 4'd4,
    KIND_ADDEAX  = 4'd5,
    KIND_JMP     = 4'd6,
    KIND_UNKNOWN = 4'd7,
    KIND_TRUNC   = 4'd8
  } kind_t;

  // Parser state: idle, seen 48, seen 48 89, collecting an immediate.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_REX   = 4'b0010,
    PH_REX89 = 4'b0100,
    PH_IMM   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [31:0] addr;
    kind_t       kind;
    logic [31:0] value;
  } result_t;

  // All results caused by one input byte, in emission order from index 0.
  typedef struct packed {
    logic [RES_CNT_W-1:0]        count;
    result_t [MAX_RESULTS-1:0]   res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_imm_op(input logic [7:0] b);
    return (b == OP_MOVIMM) || (b == OP_ADDIMM) || (b == OP_JMP);
  endfunction

  // Kind of a byte decoded on its own with nothing following it.
  function automatic kind_t byte_kind(input logic [7:0] b);
    kind_t k;
    if (b == OP_PUSH) k = KIND_PUSH;
    else if (b == OP_RET) k = KIND_RET;
    else if (b == OP_NOP) k = KIND_NOP;
    else if (is_imm_op(b)) k = KIND_TRUNC;
    else k = KIND_UNKNOWN;
    return k;
  endfunction

  // Value field of such a byte: zero for the plain one-byte instructions.
  function automatic logic [31:0] byte_value(input logic [7:0] b);
    logic [31:0] v;
    if ((b == OP_PUSH) || (b == OP_RET) || (b == OP_NOP)) v = '0;
    else v = {24'd0, b};
    return v;
  endfunction

  // Append one result to a bundle.
  function automatic bundle_t push_res(input bundle_t bd, input logic [31:0] a,
                                       input kind_t k, input logic [31:0] v);
    bundle_t r;
    r = bd;
    if (r.count < RES_CNT_W'(MAX_RESULTS)) begin
      r.res[r.count[RES_IDX_W-1:0]].addr  = a;
      r.res[r.count[RES_IDX_W-1:0]].kind  = k;
      r.res[r.count[RES_IDX_W-1:0]].value = v;
      r.count = r.count + RES_CNT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/x86pd_front.sv =====
// ----------------------------------------------------------------------------
// x86pd_front: byte parser of the x86 subset predecoder
// Takes one code byte per beat, advances the parse state and builds the
// bundle of all results that byte causes, including the end-of-code flush.
// ----------------------------------------------------------------------------
`default_nettype none

module x86pd_front #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 code_valid,
  input  wire logic                 code_stall,
  input  wire logic [7:0]           code_byte,
  input  wire logic                 end_of_code,
  output x86pd_pkg::bundle_t        wr_data,
  output logic                      wr_en
);
  import x86pd_pkg::*;

  logic [ADDR_WIDTH-1:0] byte_address, byte_address_next;
  phase_t                phase, phase_next;
  logic [7:0]            pending_opcode, pending_opcode_next;
  logic [ADDR_WIDTH-1:0] start_address, start_address_next;
  logic [31:0]           held_bytes, held_bytes_next;
  logic [2:0]            held_count, held_count_next;

  logic                  accept;
  logic                  do_fresh;
  logic [1:0]            tail_n;
  logic [ADDR_WIDTH-1:0] tail_base;
  bundle_t               bd;

  // Low 32 bits of an address, zero-extended when the address is narrower.
  function automatic logic [31:0] lo32(input logic [ADDR_WIDTH-1:0] a);
    logic [ADDR_WIDTH+31:0] w;
    w = {32'd0, a};
    return w[31:0];
  endfunction

  assign accept = code_valid && !code_stall;

  // Parse step for one byte, then the flush when the byte ends the buffer.
  always_comb begin
    phase_next          = phase;
    pending_opcode_next = pending_opcode;
    start_address_next  = start_address;
    held_bytes_next     = held_bytes;
    held_count_next     = held_count;
    byte_address_next   = byte_address + ADDR_WIDTH'(1);
    do_fresh            = 1'b0;
    tail_n              = 2'd0;
    tail_base           = '0;
    bd                  = '0;

    unique case (phase)
      PH_REX: begin
        if (code_byte == OP_MOVRM) begin
          phase_next = PH_REX89;
        end else begin
          bd       = push_res(bd, lo32(start_address), KIND_UNKNOWN, {24'd0, OP_REX});
          do_fresh = 1'b1;
        end
      end
      PH_REX89: begin
        phase_next = PH_IDLE;
        if (code_byte == OP_MODRM) begin
          bd = push_res(bd, lo32(start_address), KIND_MOVRBP, '0);
        end else begin
          bd       = push_res(bd, lo32(start_address), KIND_UNKNOWN, {24'd0, OP_REX});
          bd       = push_res(bd, lo32(start_address + ADDR_WIDTH'(1)), KIND_UNKNOWN,
                              {24'd0, OP_MOVRM});
          do_fresh = 1'b1;
        end
      end
      PH_IMM: begin
        held_bytes_next = held_bytes | ({24'd0, code_byte} << {held_count[1:0], 3'b000});
        held_count_next = held_count + 3'd1;
        if (held_count_next >= 3'd4) begin
          phase_next = PH_IDLE;
          if (pending_opcode == OP_ADDIMM) begin
            bd = push_res(bd, lo32(start_address), KIND_ADDEAX, held_bytes_next);
          end else if (pending_opcode == OP_JMP) begin
            bd = push_res(bd, lo32(start_address), KIND_JMP,
                          lo32(start_address) + 32'd5 + held_bytes_next);
          end else begin
            bd = push_res(bd, lo32(start_address), KIND_MOVEAX, held_bytes_next);
          end
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    // A byte with nothing pending in front of it.
    if (do_fresh) begin
      phase_next = PH_IDLE;
      if (code_byte == OP_REX) begin
        phase_next         = PH_REX;
        start_address_next = byte_address;
      end else if (is_imm_op(code_byte)) begin
        phase_next          = PH_IMM;
        pending_opcode_next = code_byte;
        start_address_next  = byte_address;
        held_bytes_next     = '0;
        held_count_next     = '0;
      end else begin
        bd = push_res(bd, lo32(byte_address), byte_kind(code_byte), byte_value(code_byte));
      end
    end

    // End of buffer: report what is left unfinished, then start over at zero.
    if (end_of_code) begin
      unique case (phase_next)
        PH_REX: begin
          bd = push_res(bd, lo32(start_address_next), KIND_UNKNOWN, {24'd0, OP_REX});
        end
        PH_REX89: begin
          bd = push_res(bd, lo32(start_address_next), KIND_UNKNOWN, {24'd0, OP_REX});
          bd = push_res(bd, lo32(start_address_next + ADDR_WIDTH'(1)), KIND_UNKNOWN,
                        {24'd0, OP_MOVRM});
        end
        PH_IMM: begin
          bd = push_res(bd, lo32(start_address_next), KIND_TRUNC,
                        {24'd0, pending_opcode_next});
          tail_n    = (held_count_next > 3'd3) ? 2'd3 : held_count_next[1:0];
          tail_base = start_address_next + ADDR_WIDTH'(1);
          // The held bytes are decoded again, knowing the buffer ends after them.
          if ((tail_n == 2'd3) && (held_bytes_next[7:0] == OP_REX) &&
              (held_bytes_next[15:8] == OP_MOVRM) && (held_bytes_next[23:16] == OP_MODRM)) begin
            bd = push_res(bd, lo32(tail_base), KIND_MOVRBP, '0);
          end else begin
            if (tail_n > 2'd0) begin
              bd = push_res(bd, lo32(tail_base), byte_kind(held_bytes_next[7:0]),
                            byte_value(held_bytes_next[7:0]));
            end
            if (tail_n > 2'd1) begin
              bd = push_res(bd, lo32(tail_base + ADDR_WIDTH'(1)),
                            byte_kind(held_bytes_next[15:8]),
                            byte_value(held_bytes_next[15:8]));
            end
            if (tail_n > 2'd2) begin
              bd = push_res(bd, lo32(tail_base + ADDR_WIDTH'(2)),
                            byte_kind(held_bytes_next[23:16]),
                            byte_value(held_bytes_next[23:16]));
            end
          end
        end
        default: begin
        end
      endcase
      phase_next          = PH_IDLE;
      pending_opcode_next = '0;
      start_address_next  = '0;
      held_bytes_next     = '0;
      held_count_next     = '0;
      byte_address_next   = '0;
    end
  end

  // Parse state registers advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_address   <= '0;
      phase          <= PH_IDLE;
      pending_opcode <= '0;
      start_address  <= '0;
      held_bytes     <= '0;
      held_count     <= '0;
    end else if (accept) begin
      byte_address   <= byte_address_next;
      phase          <= phase_next;
      pending_opcode <= pending_opcode_next;
      start_address  <= start_address_next;
      held_bytes     <= held_bytes_next;
      held_count     <= held_count_next;
    end
  end

  // Only bytes that cause results go into the queue.
  assign wr_en   = accept && (bd.count != '0);
  assign wr_data = bd;

  // An immediate is never left holding four or more bytes.
  a_held_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IMM) |-> (held_count < 3'd4))
    else $error("held_count out of range while collecting an immediate");

  // The end mark restarts the buffer at offset zero.
  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_code) |=> ((byte_address == '0) && (phase == PH_IDLE)))
    else $error("parser did not restart after the end mark");

endmodule

`default_nettype wire

// ===== rtl/core/x86pd_queue.sv =====
// ----------------------------------------------------------------------------
// x86pd_queue: bundle queue between front and back
// A small register FIFO of result bundles with show-ahead read data.
// ----------------------------------------------------------------------------
`default_nettype none

module x86pd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire x86pd_pkg::bundle_t   wr_data,
  input  wire logic                 rd_en,
  output x86pd_pkg::bundle_t        rd_data,
  output x86pd_pkg::q_status_t      status
);
  import x86pd_pkg::*;

  bundle_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   occ;
  logic [QPTR_W:0]   occ_next;

  assign status.full  = (occ == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (occ == '0);
  assign rd_data      = mem[rptr];

  // Occupancy follows writes and reads of the same cycle.
  always_comb begin
    occ_next = occ;
    if (wr_en && !rd_en) occ_next = occ + (QPTR_W + 1)'(1);
    else if (rd_en && !wr_en) occ_next = occ - (QPTR_W + 1)'(1);
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      occ  <= '0;
    end else begin
      if (wr_en) wptr <= wptr + QPTR_W'(1);
      if (rd_en) rptr <= rptr + QPTR_W'(1);
      occ <= occ_next;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !status.full)
    else $error("bundle written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !status.empty)
    else $error("bundle read from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/x86pd_back.sv =====
// ----------------------------------------------------------------------------
// x86pd_back: result sequencer of the x86 subset predecoder
// Takes one bundle at a time from the queue and presents its results one
// beat each, marking the last result of the bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module x86pd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire x86pd_pkg::bundle_t   rd_data,
  input  wire x86pd_pkg::q_status_t status,
  output logic                      rd_en,
  output logic                      instr_valid,
  input  wire logic                 instr_stall,
  output logic [31:0]               instr_address,
  output logic [3:0]                instr_kind,
  output logic [31:0]               instr_value,
  output logic                      last_of_run
);
  import x86pd_pkg::*;

  bundle_t              cur;
  logic                 busy;
  logic [RES_IDX_W-1:0] idx;
  logic [RES_CNT_W-1:0] cnt_m1;
  logic                 last;
  logic                 take;
  logic                 load;
  result_t              res;

  assign cnt_m1 = cur.count - RES_CNT_W'(1);
  assign last   = (idx == cnt_m1[RES_IDX_W-1:0]);
  assign take   = busy && !instr_stall;
  assign load   = !busy || (take && last);
  assign rd_en  = load && !status.empty;

  // Control: which bundle is held and which of its results is shown.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= !status.empty;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + RES_IDX_W'(1);
    end
  end

  // Bundle payload register.
  always_ff @(posedge clk) begin
    if (rd_en) cur <= rd_data;
  end

  assign res           = cur.res[idx];
  assign instr_valid   = busy;
  assign instr_address = res.addr;
  assign instr_kind    = res.kind;
  assign instr_value   = res.value;
  assign last_of_run   = last;

  // The shown result always lies inside the held bundle.
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    busy |-> (({1'b0, idx} < cur.count) && (cur.count != '0)))
    else $error("result index outside the held bundle");

endmodule

`default_nettype wire

// ===== rtl/core/x86_subset_instruction_predecoder.sv =====
// ----------------------------------------------------------------------------
// x86_subset_instruction_predecoder: top level
// Byte-stream predecoder for a small x86-64 subset with a decoupled front
// parser, a bundle queue and a result sequencer.
// ----------------------------------------------------------------------------
// The block takes one code byte per clock and reports decoded instructions
// (push rbp, ret, nop, mov rbp,rsp, mov/add eax imm32, jmp rel32, unknown
// and truncated) one result per clock while instr_stall is low. The parser
// decodes each byte combinationally and writes the results it causes, up
// to four, as one bundle into a four-entry queue; the sequencer presents a
// bundle's results one at a time. Accepted bytes' results pass through the
// queue and the sequencer's bundle register before they are presented.
// Input stalls only while the queue is full, which happens when results
// are not taken or when broken prefixes or end-of-code flushes produce
// bursts of several results faster than the output drains them. Addresses
// count bytes from zero and restart at zero after each end mark.
`default_nettype none

module x86_subset_instruction_predecoder #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        code_valid,
  output logic             code_stall,
  input  wire logic [7:0]  code_byte,
  input  wire logic        end_of_code,
  output logic             instr_valid,
  input  wire logic        instr_stall,
  output logic [31:0]      instr_address,
  output logic [3:0]       instr_kind,
  output logic [31:0]      instr_value,
  output logic             last_of_run
);
  import x86pd_pkg::*;

  bundle_t   wr_data;
  bundle_t   rd_data;
  logic      wr_en;
  logic      rd_en;
  q_status_t status;

  assign code_stall = status.full;

  x86pd_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code_byte   (code_byte),
    .end_of_code (end_of_code),
    .wr_data     (wr_data),
    .wr_en       (wr_en)
  );

  x86pd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .status  (status)
  );

  x86pd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rd_data       (rd_data),
    .status        (status),
    .rd_en         (rd_en),
    .instr_valid   (instr_valid),
    .instr_stall   (instr_stall),
    .instr_address (instr_address),
    .instr_kind    (instr_kind),
    .instr_value   (instr_value),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the x86 subset instruction predecoder
// Feeds code bytes with end marks, predicts every decoded instruction in a
// scoreboard, and checks each result beat in order, under random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import x86pd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  // One predicted instruction report.
  typedef struct packed {
    logic [31:0] addr;
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } instr_report_t;

  // Predicts the decoded instruction stream and holds the reports still due.
  class decode_scoreboard;
    logic [31:0]   next_addr;
    logic [31:0]   start_addr;
    logic [31:0]   held;
    logic [2:0]    held_cnt;
    logic [7:0]    opcode;
    phase_t        phase;
    instr_report_t burst[$];
    instr_report_t expected[$];
    int            errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      next_addr  = '0;
      start_addr = '0;
      held       = '0;
      held_cnt   = '0;
      opcode     = '0;
      phase      = PH_IDLE;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void emit(logic [31:0] a, kind_t k, logic [31:0] v);
      instr_report_t r;
      if (burst.size() < MAX_RESULTS) begin
        r.addr  = a;
        r.kind  = k;
        r.value = v;
        r.last  = 1'b0;
        burst.push_back(r);
      end
    endfunction

    // Byte seen with no instruction under way.
    function void decode_fresh(logic [7:0] b, logic [31:0] a);
      case (b)
        OP_PUSH: emit(a, KIND_PUSH, '0);
        OP_RET:  emit(a, KIND_RET, '0);
        OP_NOP:  emit(a, KIND_NOP, '0);
        OP_REX: begin
          phase      = PH_REX;
          start_addr = a;
        end
        OP_MOVIMM, OP_ADDIMM, OP_JMP: begin
          phase      = PH_IMM;
          opcode     = b;
          start_addr = a;
          held       = '0;
          held_cnt   = '0;
        end
        default: emit(a, KIND_UNKNOWN, {24'd0, b});
      endcase
    endfunction

    // All four immediate bytes are in.
    function void finish_imm();
      case (opcode)
        OP_ADDIMM: emit(start_addr, KIND_ADDEAX, held);
        OP_JMP:    emit(start_addr, KIND_JMP, start_addr + 32'd5 + held);
        default:   emit(start_addr, KIND_MOVEAX, held);
      endcase
      phase = PH_IDLE;
    endfunction

    // Re-decode the immediate bytes of a cut instruction, knowing the code ends.
    function void decode_held_tail();
      logic [7:0]  t [3];
      logic [31:0] base;
      int          n;
      int          i;
      for (int j = 0; j < 3; j++) t[j] = held[8*j +: 8];
      base = start_addr + 32'd1;
      n    = held_cnt;
      i    = 0;
      while (i < n) begin
        if (t[i] == OP_REX && i + 2 < n && t[i+1] == OP_MOVRM && t[i+2] == OP_MODRM) begin
          emit(base + i, KIND_MOVRBP, '0);
          i += 3;
        end else begin
          case (t[i])
            OP_PUSH: emit(base + i, KIND_PUSH, '0);
            OP_RET:  emit(base + i, KIND_RET, '0);
            OP_NOP:  emit(base + i, KIND_NOP, '0);
            OP_MOVIMM, OP_ADDIMM, OP_JMP: emit(base + i, KIND_TRUNC, {24'd0, t[i]});
            default: emit(base + i, KIND_UNKNOWN, {24'd0, t[i]});
          endcase
          i++;
        end
      end
    endfunction

    // End mark: report whatever is left unfinished.
    function void flush_pending();
      case (phase)
        PH_REX: emit(start_addr, KIND_UNKNOWN, {24'd0, OP_REX});
        PH_REX89: begin
          emit(start_addr, KIND_UNKNOWN, {24'd0, OP_REX});
          emit(start_addr + 32'd1, KIND_UNKNOWN, {24'd0, OP_MOVRM});
        end
        PH_IMM: begin
          emit(start_addr, KIND_TRUNC, {24'd0, opcode});
          decode_held_tail();
        end
        default: ;
      endcase
    endfunction

    // Accepted code beat: predict the reports it causes.
    function void note_byte(logic [7:0] b, logic eoc);
      logic [31:0] a;
      a = next_addr;
      burst.delete();
      case (phase)
        PH_REX: begin
          if (b == OP_MOVRM) begin
            phase = PH_REX89;
          end else begin
            emit(start_addr, KIND_UNKNOWN, {24'd0, OP_REX});
            phase = PH_IDLE;
            decode_fresh(b, a);
          end
        end
        PH_REX89: begin
          phase = PH_IDLE;
          if (b == OP_MODRM) begin
            emit(start_addr, KIND_MOVRBP, '0);
          end else begin
            emit(start_addr, KIND_UNKNOWN, {24'd0, OP_REX});
            emit(start_addr + 32'd1, KIND_UNKNOWN, {24'd0, OP_MOVRM});
            decode_fresh(b, a);
          end
        end
        PH_IMM: begin
          held     = held | ({24'd0, b} << (8 * held_cnt[1:0]));
          held_cnt = held_cnt + 3'd1;
          if (held_cnt >= 3'd4) finish_imm();
        end
        default: begin
          phase = PH_IDLE;
          decode_fresh(b, a);
        end
      endcase
      if (eoc) begin
        flush_pending();
        clear();
      end else begin
        next_addr = a + 32'd1;
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected.push_back(burst[i]);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endfunction

    // Accepted result beat: compare with the oldest report still due.
    function void check_result(logic [31:0] a, logic [3:0] k, logic [31:0] v, logic l);
      instr_report_t e;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: address %h kind %0d value %h last %b",
                 $time, a, k, v, l);
        return;
      end
      e = expected.pop_front();
      if (e.addr !== a) flag("address", e.addr, a);
      if (e.kind !== k) flag("kind", {28'd0, e.kind}, {28'd0, k});
      if (e.value !== v) flag("value", e.value, v);
      if (e.last !== l) flag("last_of_run", {31'd0, e.last}, {31'd0, l});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        code_valid = 1'b0;
  logic        code_stall;
  logic [7:0]  code_byte = '0;
  logic        end_of_code = 1'b0;
  logic        instr_valid;
  logic        instr_stall = 1'b0;
  logic [31:0] instr_address;
  logic [3:0]  instr_kind;
  logic [31:0] instr_value;
  logic        last_of_run;

  int          send_idle = 0;
  int          recv_idle = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  prog[$];

  decode_scoreboard sb = new();

  x86_subset_instruction_predecoder dut (
    .clk          (clk),
    .rst          (rst),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_byte    (code_byte),
    .end_of_code  (end_of_code),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr_address(instr_address),
    .instr_kind   (instr_kind),
    .instr_value  (instr_value),
    .last_of_run  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both channels are observed at the clock edge; inputs are noted before
  // results so the prediction is ready whatever the output latency.
  always @(posedge clk) begin
    if (!rst) begin
      if (code_valid && !code_stall) sb.note_byte(code_byte, end_of_code);
      if (instr_valid && !instr_stall)
        sb.check_result(instr_address, instr_kind, instr_value, last_of_run);
      if ((code_valid && !code_stall) || (instr_valid && !instr_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      instr_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog on cycles with no beat on either channel.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // One code beat, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic eoc);
    while ($urandom_range(99) < send_idle) begin
      code_valid <= 1'b0;
      @(posedge clk);
    end
    code_valid  <= 1'b1;
    code_byte   <= b;
    end_of_code <= eoc;
    @(posedge clk);
    while (code_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sends the bytes in prog, marking the last one as the end if asked.
  task automatic send_prog(input logic end_mark);
    foreach (prog[i]) send_byte(prog[i], end_mark && (i == prog.size() - 1));
  endtask

  // Holds the sender off until every predicted report has come out.
  task automatic drain_results();
    code_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Appends one mostly well-formed instruction with random content.
  task automatic add_instr();
    int          pick;
    logic [31:0] imm;
    pick = $urandom_range(99);
    case ($urandom_range(7))
      0:       imm = 32'h0000_0000;
      1:       imm = 32'hFFFF_FFFF;
      2:       imm = 32'h8000_0000;
      default: imm = $urandom;
    endcase
    if (pick < 12) prog.push_back(OP_PUSH);
    else if (pick < 22) prog.push_back(OP_RET);
    else if (pick < 32) prog.push_back(OP_NOP);
    else if (pick < 46) begin
      prog.push_back(OP_REX);
      prog.push_back(OP_MOVRM);
      prog.push_back(OP_MODRM);
    end else if (pick < 82) begin
      if (pick < 58) prog.push_back(OP_MOVIMM);
      else if (pick < 70) prog.push_back(OP_ADDIMM);
      else prog.push_back(OP_JMP);
      for (int i = 0; i < 4; i++) prog.push_back(imm[8*i +: 8]);
    end else if (pick < 88) begin
      prog.push_back(8'($urandom_range(255)));
    end else if (pick < 94) begin
      // Prefix followed by an arbitrary byte.
      prog.push_back(OP_REX);
      prog.push_back(8'($urandom_range(255)));
    end else begin
      prog.push_back(OP_REX);
      prog.push_back(OP_MOVRM);
      prog.push_back(8'($urandom_range(255)));
    end
  endtask

  // Random code buffers, some cut short, most closed by an end mark.
  task automatic random_phase(input int count);
    int goal;
    int cut;
    goal = items_sent + count;
    while (items_sent < goal) begin
      prog.delete();
      repeat ($urandom_range(1, 10)) add_instr();
      if ($urandom_range(3) == 0 && prog.size() > 1) begin
        cut = $urandom_range(1, (prog.size() > 3) ? 3 : prog.size() - 1);
        repeat (cut) void'(prog.pop_back());
      end
      send_prog($urandom_range(7) != 0);
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, sender idling 28 and receiver 45 in a hundred.
    send_idle = 28;
    recv_idle = 45;
    // One-byte instructions and mov rbp,rsp.
    prog = '{OP_PUSH, OP_RET, OP_NOP, OP_REX, OP_MOVRM, OP_MODRM};
    send_prog(1'b0);
    // Immediate with extreme bytes, and a jump back onto itself.
    prog = '{OP_MOVIMM, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_prog(1'b0);
    prog = '{OP_JMP, 8'hFB, 8'hFF, 8'hFF, 8'hFF};
    send_prog(1'b0);
    // Broken prefixes: 48 then push, and 48 89 then a stray byte.
    prog = '{OP_REX, OP_PUSH};
    send_prog(1'b0);
    prog = '{OP_REX, OP_MOVRM, 8'h00};
    send_prog(1'b0);
    // Prefix cut by the end mark.
    prog = '{OP_REX, OP_MOVRM};
    send_prog(1'b1);
    // Immediate cut by the end mark with only opcodes held: four reports.
    prog = '{OP_MOVIMM, OP_MOVIMM, OP_ADDIMM, OP_JMP};
    send_prog(1'b1);
    drain_results();

    random_phase(72);
    send_idle = 45;
    recv_idle = 28;
    random_phase(72);
    send_idle = 0;
    recv_idle = 0;
    random_phase(72);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
